@@ hdl/aetc_pkg.sv @@
// shared constants, types and codes of the absolute encoder tick counter
`timescale 1ns / 1ps

package aetc_pkg;

  // field widths
  localparam int SAMPLE_W  = 12;
  localparam int LEVEL_W   = SAMPLE_W + 2;
  localparam int COUNT_W   = 16;
  localparam int RES_W     = 12;
  localparam int DIR_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // arithmetic widths
  localparam int CMP_W     = LEVEL_W + 6;
  localparam int DIVD_W    = LEVEL_W;
  localparam int SUM_W     = COUNT_W + 2;
  localparam int DIV_STEPS = DIVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RESOLUTION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_DIRECTION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_UPPER      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_LOWER      = 3'd5;

  // count direction codes
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd1;

  // register reset values
  localparam logic [SAMPLE_W-1:0]       FULL_SCALE_RST = 12'd1023;
  localparam logic [SAMPLE_W-1:0]       LOWEST_RST     = 12'd0;
  localparam logic [RES_W-1:0]          RES_RST        = 12'd1;
  localparam logic signed [COUNT_W-1:0] UPPER_RST      = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] LOWER_RST      = 16'sh8000;

  typedef struct packed {
    logic [SAMPLE_W-1:0]       full_scale;
    logic [SAMPLE_W-1:0]       lowest_level;
    logic [RES_W-1:0]          tick_resolution;
    logic [DIR_W-1:0]          count_direction;
    logic signed [COUNT_W-1:0] tick_upper;
    logic signed [COUNT_W-1:0] tick_lower;
  } cfg_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

@@ hdl/aetc_if.sv @@
// valid/ready channel interfaces for sample items, tick items and register writes
`timescale 1ns / 1ps

interface aetc_in_if import aetc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface aetc_out_if import aetc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COUNT_W-1:0] ticks;

  modport source (output valid, output ticks, input ready);
  modport sink   (input valid, input ticks, output ready);
endinterface

interface aetc_cfg_if import aetc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/aetc_cfg.sv @@
// configuration register file
`timescale 1ns / 1ps

module aetc_cfg import aetc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register decode, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_FULL_SCALE:      cfg_nxt.full_scale      = cfg_data[SAMPLE_W-1:0];
        CFG_LOWEST_LEVEL:    cfg_nxt.lowest_level    = cfg_data[SAMPLE_W-1:0];
        CFG_TICK_RESOLUTION: cfg_nxt.tick_resolution = cfg_data[RES_W-1:0];
        CFG_COUNT_DIRECTION: cfg_nxt.count_direction = cfg_data[DIR_W-1:0];
        CFG_TICK_UPPER:      cfg_nxt.tick_upper      = $signed(cfg_data[COUNT_W-1:0]);
        CFG_TICK_LOWER:      cfg_nxt.tick_lower      = $signed(cfg_data[COUNT_W-1:0]);
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_scale      <= FULL_SCALE_RST;
      cfg_r.lowest_level    <= LOWEST_RST;
      cfg_r.tick_resolution <= RES_RST;
      cfg_r.count_direction <= DIR_UP;
      cfg_r.tick_upper      <= UPPER_RST;
      cfg_r.tick_lower      <= LOWER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hdl/aetc_ctrl.sv @@
// sequencing state machine and result handshake
`timescale 1ns / 1ps

module aetc_ctrl import aetc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output ctrl_cmd_t  cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] step_cnt_r, step_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_step;

  assign last_step = (step_cnt_r == CNT_W'(DIV_STEPS - 1));
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    step_cnt_nxt = step_cnt_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep     = 1'b1;
        step_cnt_nxt = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_cnt_nxt = step_cnt_r + 1'b1;
        if (last_step) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_cnt_r  <= step_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a new result never overwrites one that is still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  // the divide runs exactly its step count before the update
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && last_step) |=> (state_r == S_DONE))
    else $error("divide did not finish after its last step");

  // every accepted item starts with the prep cycle and a cleared step count
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ##1 (state_r == S_DIV && step_cnt_r == '0))
    else $error("accepted item did not start the divide cleanly");

endmodule

@@ hdl/aetc_dp.sv @@
// datapath: wrap detection, move test, restoring divider and count update
`timescale 1ns / 1ps

module aetc_dp import aetc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ctrl_cmd_t                 cmd,
  input  cfg_t                      cfg,
  input  logic [SAMPLE_W-1:0]       in_sample,
  output logic signed [COUNT_W-1:0] out_ticks
);

  // item and kept state
  logic [SAMPLE_W-1:0]       sample_r;
  logic signed [LEVEL_W-1:0] prev_r, prev_nxt;
  logic signed [COUNT_W-1:0] tick_r, tick_nxt;
  logic                      await_r, await_nxt;
  logic signed [COUNT_W-1:0] out_ticks_r;

  // prep results and divider
  logic signed [LEVEL_W-1:0] padj_r;
  logic                      rise_r, fall_r;
  logic [RES_W-1:0]          div_r;
  logic [RES_W-1:0]          rem_r, rem_nxt;
  logic [DIVD_W-1:0]         quo_r, quo_nxt;

  // prep cycle signals
  logic signed [CMP_W-1:0] s_w, fs_w, lo_w, p_w, res_w;
  logic signed [CMP_W-1:0] s10, p10, fs7, fs3;
  logic signed [CMP_W-1:0] p_adj, diff, absd;
  logic                    wrap_up, wrap_dn, rise, fall;
  logic [RES_W-1:0]        res_eff;

  // divide step signals
  logic [RES_W:0] rem_sh, rem_sub;
  logic           ge;

  // commit signals
  logic signed [SUM_W-1:0] t_w, q_w, t_mv, t0, t1, t2, up_w, lo_cnt_w;
  logic                    moved, add_q, sub_q;

  assign out_ticks = out_ticks_r;

  // operand extension into the compare width
  always_comb begin
    s_w     = $signed({{(CMP_W-SAMPLE_W){1'b0}}, sample_r});
    fs_w    = $signed({{(CMP_W-SAMPLE_W){1'b0}}, cfg.full_scale});
    lo_w    = $signed({{(CMP_W-SAMPLE_W){1'b0}}, cfg.lowest_level});
    p_w     = {{(CMP_W-LEVEL_W){prev_r[LEVEL_W-1]}}, prev_r};
    res_eff = (cfg.tick_resolution == '0) ? RES_W'(1) : cfg.tick_resolution;
    res_w   = $signed({{(CMP_W-RES_W){1'b0}}, res_eff});
  end

  // 70% and 30% marks compared exactly as 10*v against 7*fs and 3*fs
  always_comb begin
    s10 = (s_w <<< 3) + (s_w <<< 1);
    p10 = (p_w <<< 3) + (p_w <<< 1);
    fs7 = (fs_w <<< 3) - fs_w;
    fs3 = (fs_w <<< 1) + fs_w;
    wrap_up = (s10 > fs7) && (s_w <= fs_w) && (p_w >= lo_w) && (p10 < fs3);
    wrap_dn = !wrap_up && (p10 > fs7) && (p_w <= fs_w) && (s_w >= lo_w)
              && (s10 < fs3);
    if (wrap_up) begin
      p_adj = p_w + fs_w;
    end else if (wrap_dn) begin
      p_adj = p_w - fs_w;
    end else begin
      p_adj = p_w;
    end
  end

  // move test and magnitude of the move
  always_comb begin
    rise = (s_w >= p_adj + res_w);
    fall = !rise && (s_w <= p_adj - res_w);
    diff = s_w - p_adj;
    absd = diff[CMP_W-1] ? -diff : diff;
  end

  // one restoring divide step
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIVD_W-1]};
    rem_sub = rem_sh - {1'b0, div_r};
    ge      = (rem_sh >= {1'b0, div_r});
    rem_nxt = ge ? rem_sub[RES_W-1:0] : rem_sh[RES_W-1:0];
    quo_nxt = {quo_r[DIVD_W-2:0], ge};
  end

  // count update, first-change clear and bound wrap
  always_comb begin
    t_w      = {{(SUM_W-COUNT_W){tick_r[COUNT_W-1]}}, tick_r};
    q_w      = $signed({{(SUM_W-DIVD_W){1'b0}}, quo_r});
    up_w     = {{(SUM_W-COUNT_W){cfg.tick_upper[COUNT_W-1]}}, cfg.tick_upper};
    lo_cnt_w = {{(SUM_W-COUNT_W){cfg.tick_lower[COUNT_W-1]}}, cfg.tick_lower};
    moved    = rise_r || fall_r;
    add_q    = (cfg.count_direction == DIR_UP && rise_r)
               || (cfg.count_direction == DIR_DOWN && fall_r);
    sub_q    = (cfg.count_direction == DIR_UP && fall_r)
               || (cfg.count_direction == DIR_DOWN && rise_r);
    if (add_q) begin
      t_mv = t_w + q_w;
    end else if (sub_q) begin
      t_mv = t_w - q_w;
    end else begin
      t_mv = t_w;
    end
    t0 = (moved && await_r) ? '0 : t_mv;
    t1 = (t0 > up_w) ? lo_cnt_w : t0;
    t2 = (t1 < lo_cnt_w) ? up_w : t1;
    tick_nxt  = t2[COUNT_W-1:0];
    prev_nxt  = moved ? $signed({{(LEVEL_W-SAMPLE_W){1'b0}}, sample_r}) : padj_r;
    await_nxt = await_r && !moved;
  end

  // kept state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      tick_r  <= '0;
      await_r <= 1'b1;
    end else if (cmd.commit) begin
      prev_r  <= prev_nxt;
      tick_r  <= tick_nxt;
      await_r <= await_nxt;
    end
  end

  // item payload, prep results, divider and output registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
    end
    if (cmd.prep) begin
      padj_r <= p_adj[LEVEL_W-1:0];
      rise_r <= rise;
      fall_r <= fall;
      div_r  <= res_eff;
      rem_r  <= '0;
      quo_r  <= absd[DIVD_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.commit) begin
      out_ticks_r <= tick_nxt;
    end
  end

  // the partial remainder always stays below the divisor
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < div_r))
    else $error("divider remainder reached the divisor");

  // rise and fall are never both taken for one item
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !(rise_r && fall_r))
    else $error("move seen in both directions");

endmodule

@@ hdl/absolute_encoder_tick_counter_core.sv @@
// Absolute encoder wrap-around tick counter, top level.
// Each accepted sample item runs a prep step, 14 restoring divide steps and an update
//   step, which waits while the previous result has not yet been taken.
// The one-bit-per-cycle divider works on one item at a time; a new item is taken only when idle.
// A finished result waits in an output register while the next item is taken.
// Synchronous active-low reset: count 0, previous level 0, first-change wait set,
//   registers back to their default values.
`timescale 1ns / 1ps

module absolute_encoder_tick_counter_core import aetc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  aetc_in_if.sink           in_ch,
  aetc_out_if.source        out_ch,
  aetc_cfg_if.sink          cfg_ch
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;

  // configuration registers
  aetc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .cfg       (cfg)
  );

  // sequencer
  aetc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // arithmetic and kept state
  aetc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (cfg),
    .in_sample (in_ch.sample),
    .out_ticks (out_ch.ticks)
  );

endmodule
